@@ design/assert_macros.svh @@
// Assertion macros used by the RTL of the skip-ahead unit.
// No dependencies; included by lcg_minstd_skip_ahead_unit, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

@@ design/lcgms_pkg.sv @@
// Package of the minimal standard generator skip-ahead unit: item types,
// modulus constants, Mersenne folding and the table of squared multipliers.
// No dependencies.
`default_nettype none

package lcgms_pkg;

   localparam int COUNT_BITS = 64;
   // The sign bit is never used for a multiply.
   localparam int BIT_LIMIT  = (COUNT_BITS > 63) ? 63 : COUNT_BITS;
   localparam int IDX_W      = $clog2(BIT_LIMIT);

   localparam logic [31:0] MOD31      = 32'h7FFF_FFFF;
   localparam logic [30:0] MULTIPLIER = 31'd16807;

   typedef struct packed {
      logic [30:0]        seed_in;
      logic signed [63:0] skip_count;
   } req_item_type;

   typedef struct packed {
      logic [30:0] seed_out;
      logic        count_error;
   } rsp_item_type;

   typedef logic [BIT_LIMIT-1:0][30:0] pow_table_type;

   // Two Mersenne folds and a final conditional subtract: always below 2^31-1.
   function automatic logic [30:0] fold31(input logic [61:0] x);
      logic [31:0] s1;
      logic [31:0] s2;
      s1 = {1'b0, x[30:0]} + {1'b0, x[61:31]};
      s2 = {1'b0, s1[30:0]} + 32'(s1[31]);
      if (s2 >= MOD31) begin
         s2 = s2 - MOD31;
      end
      return s2[30:0];
   endfunction

   function automatic logic [30:0] mulmod31(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] x;
      x = 62'(a) * 62'(b);
      return fold31(x);
   endfunction

   // Entry k holds 16807^(2^k) mod 2^31-1; evaluated at elaboration.
   function automatic pow_table_type build_pow_table();
      pow_table_type t;
      logic [30:0]   p;
      p = MULTIPLIER;
      for (int k = 0; k < BIT_LIMIT; k++) begin
         t[k] = p;
         p    = mulmod31(p, p);
      end
      return t;
   endfunction

   localparam pow_table_type POW_TABLE = build_pow_table();

endpackage

`default_nettype wire

@@ design/lcgms_mulmod.sv @@
// Shared modular multiply unit: registered 31x31 product, then Mersenne
// folding to a fully reduced residue. Depends on lcgms_pkg.
`default_nettype none

module lcgms_mulmod
   import lcgms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        mul_en,
   input  wire logic [30:0] mul_a,
   input  wire logic [30:0] mul_b,
   output logic      [30:0] fold_out
);

   logic [61:0] product_ff;
   logic [61:0] product_in;

   assign product_in = 62'(mul_a) * 62'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   assign fold_out = fold31(product_ff);

endmodule

`default_nettype wire

@@ design/lcg_minstd_skip_ahead_unit.sv @@
// Channel   Direction  Payload         Handshake
// req_      in         req_item_type   req_valid / req_ready
// rsp_      out        rsp_item_type   rsp_valid / rsp_ready
//
// From acceptance an item visits the scan state once per count bit up to its highest
// set bit and once more at the end; each set bit also passes the multiply state, where
// the shared multiply unit registers the product, and the fold state, which stores the seed.
// A zero count goes from scan straight to finish, a negative count from idle to finish.
// Synchronous reset clears the sequencer and the result valid flag. A stalled result is
// held in its register; the next item is taken while it waits, and its own result waits
// in the finish state until that register frees.
// Depends on lcgms_pkg, lcgms_mulmod and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lcg_minstd_skip_ahead_unit
   import lcgms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_MUL    = 5'b00100,
      ST_FOLD   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [30:0]          seed_ff, seed_in;
   logic [BIT_LIMIT-1:0] count_ff, count_in;
   logic [IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic                 err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   logic                 mul_en;
   logic [30:0]          fold_out;
   logic                 slot_free;

   lcgms_mulmod u_mulmod (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_a    (seed_ff),
      .mul_b    (POW_TABLE[bit_idx_ff]),
      .fold_out (fold_out)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign mul_en    = (state_ff == ST_MUL);

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      count_in     = count_ff;
      bit_idx_in   = bit_idx_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seed_in    = req_data.seed_in;
               count_in   = req_data.skip_count[BIT_LIMIT-1:0];
               bit_idx_in = '0;
               err_in     = req_data.skip_count[63];
               state_in   = req_data.skip_count[63] ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Bits already consumed are shifted out, so zero means done.
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else if (count_ff[0]) begin
               state_in = ST_MUL;
            end else begin
               count_in   = count_ff >> 1;
               bit_idx_in = IDX_W'(bit_idx_ff + 1'b1);
            end
         end
         ST_MUL: begin
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            seed_in    = fold_out;
            count_in   = count_ff >> 1;
            bit_idx_in = IDX_W'(bit_idx_ff + 1'b1);
            state_in   = ST_SCAN;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.seed_out     = seed_ff;
               rsp_data_in.count_error  = err_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      count_ff    <= count_in;
      bit_idx_ff  <= bit_idx_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_neg_goes_finish, clock, reset,
      req_valid && req_ready && req_data.skip_count[63],
      state_ff == ST_FINISH && err_ff)
   `ASSERT_IMPL(a_fold_after_mul, clock, reset, state_ff == ST_FOLD,
      $past(state_ff) == ST_MUL)
   `ASSERT_IMPL(a_fold_reduced, clock, reset, state_ff == ST_FOLD,
      fold_out != MOD31[30:0])
   `ASSERT_IMPL(a_mul_bit_set, clock, reset, state_ff == ST_MUL,
      count_ff[0] && !err_ff)

endmodule

`default_nettype wire

@@ verif/lcg_minstd_skip_ahead_unit_test.sv @@
// Self-checking testbench of the minimal standard generator skip-ahead unit.
// It drives seed and skip count items, predicts each jumped seed and compares the results.
// Depends on lcgms_pkg and the RTL of lcg_minstd_skip_ahead_unit.

module lcg_minstd_skip_ahead_unit_test;
   import lcgms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PRIME31    = 64'h7FFF_FFFF;
   localparam bit [30:0]       SEED_TOP   = 31'h7FFF_FFFF;
   localparam int              JUMP_BITS  = 63;
   localparam int              ITEM_TOTAL = 1350;
   localparam int              DRAIN_WAIT = 250;
   localparam int              CYCLE_CAP  = 2_000_000;
   localparam int              PRINT_CAP  = 40;

   // Expected jumped seeds, kept in order of acceptance.
   class seed_scoreboard;
      rsp_item_type expected_q[$];
      bit [30:0]    jump_pow[JUMP_BITS];
      int           errors;

      function new();
         errors = 0;
         jump_pow[0] = 31'd16807;
         for (int k = 1; k < JUMP_BITS; k++) begin
            jump_pow[k] = mod_product(jump_pow[k-1], jump_pow[k-1]);
         end
      endfunction

      function bit [30:0] mod_product(bit [30:0] a, bit [30:0] b);
         longint unsigned x;
         longint unsigned y;
         x = a;
         y = b;
         return 31'((x * y) % PRIME31);
      endfunction

      function void note_request(req_item_type req);
         rsp_item_type exp_rsp;
         exp_rsp.seed_out    = req.seed_in;
         exp_rsp.count_error = req.skip_count[63];
         if (!req.skip_count[63]) begin
            for (int k = 0; k < JUMP_BITS; k++) begin
               if (req.skip_count[k]) begin
                  exp_rsp.seed_out = mod_product(exp_rsp.seed_out, jump_pow[k]);
               end
            end
         end
         expected_q.push_back(exp_rsp);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, msg);
         end
      endtask

      task check_result(rsp_item_type rsp);
         rsp_item_type exp_rsp;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result seed %0d error %0d",
                                      rsp.seed_out, rsp.count_error));
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp.seed_out !== exp_rsp.seed_out) begin
               report_mismatch($sformatf("seed_out %0d, expected %0d",
                                         rsp.seed_out, exp_rsp.seed_out));
            end
            if (rsp.count_error !== exp_rsp.count_error) begin
               report_mismatch($sformatf("count_error %0d, expected %0d",
                                         rsp.count_error, exp_rsp.count_error));
            end
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;

   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int cycle_count = 0;

   seed_scoreboard board = new();

   lcg_minstd_skip_ahead_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Handshakes are sampled in the active region, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Valid is only lowered when a gap follows, so back-to-back items keep it high.
   task automatic send_request(input bit [30:0] seed, input logic signed [63:0] count);
      int gap;
      gap = req_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.seed_in    <= seed;
      req_data.skip_count <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic bit [30:0] pick_seed();
      case ($urandom_range(0, 15))
         0:       return 31'd0;
         1:       return 31'd1;
         2:       return SEED_TOP - 31'd1;
         3:       return SEED_TOP;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic signed [63:0] pick_count();
      logic [63:0] c;
      case ($urandom_range(0, 9))
         0, 1: c = {$urandom, $urandom};
         2, 3: c = {1'b0, 31'($urandom), $urandom};
         4, 5: c = 64'($urandom_range(0, 1023));
         6:    c = 64'd1 << $urandom_range(0, 62);
         7: begin
            c = (64'd1 << $urandom_range(0, 62)) | (64'd1 << $urandom_range(0, 62))
                | (64'd1 << $urandom_range(0, 62));
         end
         8:    c = -64'($urandom_range(1, 1023));
         default: begin
            c = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
         end
      endcase
      return c;
   endfunction

   // Result side: a random stall before each item, with stall-free stretches.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero and negative counts, the longest jump, the
      // seed congruent to zero, single high bits and alternating patterns.
      send_request(31'd12345, 64'sd0);
      send_request(31'd12345, -64'sd1);
      send_request(31'd12345, 64'sh8000_0000_0000_0000);
      send_request(31'd1, 64'sd1);
      send_request(31'd1, 64'sd2);
      send_request(31'd1, 64'sd10000);
      send_request(31'd1, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_request(SEED_TOP, 64'sd0);
      send_request(SEED_TOP, 64'sd5);
      send_request(SEED_TOP, -64'sd1);
      send_request(31'd0, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_request(31'd0, 64'sd0);
      send_request(SEED_TOP - 31'd1, 64'sd1);
      send_request(31'd1, 64'sh4000_0000_0000_0000);
      send_request(31'd1, 64'sh0000_0000_8000_0000);
      send_request(31'd1, 64'sh0000_0001_0000_0000);
      send_request(31'h5555_5555, 64'sh5555_5555_5555_5555);
      send_request(31'h2AAA_AAAA, 64'sh2AAA_AAAA_AAAA_AAAA);
      send_request(31'h2AAA_AAAA, 64'shAAAA_AAAA_AAAA_AAAA);
      send_request(SEED_TOP - 31'd1, 64'sh7FFF_FFFF_FFFF_FFFF);
      sent = 20;

      // Random part in blocks, each with its own idling on either side.
      while (sent < ITEM_TOTAL) begin
         req_idle = $urandom_range(0, 3) != 0;
         rsp_idle = $urandom_range(0, 3) != 0;
         repeat (150) begin
            if (sent < ITEM_TOTAL) begin
               send_request(pick_seed(), pick_count());
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/lcgms_pkg.sv
design/lcgms_mulmod.sv
design/lcg_minstd_skip_ahead_unit.sv
verif/lcg_minstd_skip_ahead_unit_test.sv
